### src/vsac_pkg.sv
// ----------------------------------------------------------------------------
// vsac_pkg: shared types and constants of the vital sign alarm controller
// Holds the alarm and level codes, register indexes, reset values, timing
// intervals, tone values and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package vsac_pkg;

  localparam int RAW_W   = 10;
  localparam int TEMP_W  = 9;
  localparam int PULSE_W = 8;
  localparam int TONE_W  = 11;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  typedef enum logic [1:0] {
    ALARM_NORMAL   = 2'd0,
    ALARM_ALERT    = 2'd1,
    ALARM_CRITICAL = 2'd2
  } alarm_t;

  typedef enum logic [1:0] {
    LEVEL_NORMAL = 2'd0,
    LEVEL_LOW    = 2'd1,
    LEVEL_HIGH   = 2'd2
  } level_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TEMP_LOW   = 3'd0,
    REG_TEMP_HIGH  = 3'd1,
    REG_PULSE_LOW  = 3'd2,
    REG_PULSE_HIGH = 3'd3,
    REG_MUTE       = 3'd4,
    REG_BLINK      = 3'd5
  } reg_idx_t;

  // Register reset values.
  localparam logic [TEMP_W-1:0]  TEMP_LOW_RST   = 9'd10;
  localparam logic [TEMP_W-1:0]  TEMP_HIGH_RST  = 9'd390;
  localparam logic [PULSE_W-1:0] PULSE_LOW_RST  = 8'd60;
  localparam logic [PULSE_W-1:0] PULSE_HIGH_RST = 8'd100;
  localparam logic [CFG_W-1:0]   MUTE_RST       = 16'd187;
  localparam logic [CFG_W-1:0]   BLINK_RST      = 16'd31;

  // Scaling constants.
  localparam int TEMP_SAT    = 500;
  localparam int PULSE_MIN   = 30;
  localparam int PULSE_SPAN  = 170;
  localparam int PULSE_MAX   = 200;
  localparam int SCALE_SHIFT = 24;

  // Beep intervals in ticks and tone values in Hz, by alarm state.
  localparam logic [6:0] BEEP_IVL_NORMAL = 7'd124;
  localparam logic [6:0] BEEP_IVL_ALERT  = 7'd49;
  localparam logic [6:0] BEEP_IVL_CRIT   = 7'd15;

  localparam logic [TONE_W-1:0] TONE_NORMAL = 11'd800;
  localparam logic [TONE_W-1:0] TONE_ALERT  = 11'd1200;
  localparam logic [TONE_W-1:0] TONE_CRIT   = 11'd2000;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_low;
    logic [TEMP_W-1:0]  temp_high;
    logic [PULSE_W-1:0] pulse_low;
    logic [PULSE_W-1:0] pulse_high;
    logic [CFG_W-1:0]   mute_ticks;
    logic [CFG_W-1:0]   blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic               tick_advance;
    logic               button_press;
    level_t             temp_status;
    level_t             pulse_status;
    logic [TEMP_W-1:0]  temp_tenths;
    logic [PULSE_W-1:0] pulse_bpm;
  } scaled_t;

  typedef struct packed {
    logic              led_on;
    logic              beep_phase;
    logic [TONE_W-1:0] tone_hz;
    alarm_t            alarm_state;
    logic              state_changed;
    logic              mute_started;
  } alarm_res_t;

  // Low is tested first; with inverted limits a value below the low limit reports low and any other reports high.
  function automatic level_t classify(input logic [TEMP_W-1:0] v,
                                      input logic [TEMP_W-1:0] lo,
                                      input logic [TEMP_W-1:0] hi);
    level_t r;
    if (v < lo) begin
      r = LEVEL_LOW;
    end else if (v > hi) begin
      r = LEVEL_HIGH;
    end else begin
      r = LEVEL_NORMAL;
    end
    return r;
  endfunction

endpackage

### src/vital_sign_alarm_controller.sv
// ----------------------------------------------------------------------------
// vital_sign_alarm_controller: patient monitor alarm controller
// Scales temperature and pulse readings, classifies them, and drives the
// alarm state, a blinking LED and a beeping tone with a button mute window.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ---------------------------------------
//   input    in_valid / in_ready     tick_advance, temp_raw, pulse_raw,
//                                    button_press
//   output   out_valid / out_ready   led_on, beep_phase, tone_hz, alarm_state,
//                                    temp_status, pulse_status, temp_tenths,
//                                    pulse_bpm, state_changed, mute_started
//   config   cfg_write               cfg_index, cfg_data (write only)
//
// The block sustains one transfer per cycle on each channel while the output
// is not stalled. An item passes through three registers in order: the input
// register, the scaled-reading register (after the reciprocal multiply and
// the limit compares) and the result register (after the alarm and timer
// update). Each stage holds its item only while the stage after it is full
// and stalled, so a stalled output still lets the input side fill the empty
// stages behind it. Reset clears the valid flags, the configuration
// registers to their defaults and all alarm and timer state.
// ----------------------------------------------------------------------------
module vital_sign_alarm_controller #(
  parameter int TICK_BITS      = 32,
  parameter int ADC_FULL_SCALE = 1023
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         tick_advance,
  input  logic [vsac_pkg::RAW_W-1:0]   temp_raw,
  input  logic [vsac_pkg::RAW_W-1:0]   pulse_raw,
  input  logic                         button_press,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         led_on,
  output logic                         beep_phase,
  output logic [vsac_pkg::TONE_W-1:0]  tone_hz,
  output logic [1:0]                   alarm_state,
  output logic [1:0]                   temp_status,
  output logic [1:0]                   pulse_status,
  output logic [vsac_pkg::TEMP_W-1:0]  temp_tenths,
  output logic [vsac_pkg::PULSE_W-1:0] pulse_bpm,
  output logic                         state_changed,
  output logic                         mute_started,

  input  logic                         cfg_write,
  input  logic [vsac_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vsac_pkg::CFG_W-1:0]   cfg_data
);
  import vsac_pkg::*;

  // Configuration registers. Writes to an unused index are dropped.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_low    <= TEMP_LOW_RST;
      cfg.temp_high   <= TEMP_HIGH_RST;
      cfg.pulse_low   <= PULSE_LOW_RST;
      cfg.pulse_high  <= PULSE_HIGH_RST;
      cfg.mute_ticks  <= MUTE_RST;
      cfg.blink_ticks <= BLINK_RST;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_TEMP_LOW:   cfg.temp_low    <= cfg_data[TEMP_W-1:0];
        REG_TEMP_HIGH:  cfg.temp_high   <= cfg_data[TEMP_W-1:0];
        REG_PULSE_LOW:  cfg.pulse_low   <= cfg_data[PULSE_W-1:0];
        REG_PULSE_HIGH: cfg.pulse_high  <= cfg_data[PULSE_W-1:0];
        REG_MUTE:       cfg.mute_ticks  <= cfg_data;
        REG_BLINK:      cfg.blink_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage handshakes. A stage can take a new item when it is empty or when
  // its current item moves on in the same cycle.
  logic a_valid, b_valid;
  logic out_free, b_free, a_move, b_move, in_xfer;

  assign out_free = !out_valid || out_ready;
  assign b_free   = !b_valid || out_free;
  assign in_ready = !a_valid || b_free;
  assign in_xfer  = in_valid && in_ready;
  assign a_move   = a_valid && b_free;
  assign b_move   = b_valid && out_free;

  // Input register: raw fields as transferred.
  logic               a_tick, a_press;
  logic [RAW_W-1:0]   a_temp_raw, a_pulse_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_xfer || (a_valid && !b_free);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_tick      <= tick_advance;
      a_press     <= button_press;
      a_temp_raw  <= temp_raw;
      a_pulse_raw <= pulse_raw;
    end
  end

  // Scaling and classification of the readings; these do not depend on the
  // alarm state, so they run one stage ahead of it.
  scaled_t scaled, b_item;

  vsac_scale #(
    .ADC_FULL_SCALE(ADC_FULL_SCALE)
  ) u_scale (
    .temp_raw    (a_temp_raw),
    .pulse_raw   (a_pulse_raw),
    .tick_advance(a_tick),
    .button_press(a_press),
    .cfg         (cfg),
    .item        (scaled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_move || (b_valid && !out_free);
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_item <= scaled;
    end
  end

  // Alarm and timer state advance exactly once per item, when the item
  // moves into the result register.
  alarm_res_t alarm_res, out_res;

  vsac_alarm #(
    .TICK_BITS(TICK_BITS)
  ) u_alarm (
    .clk   (clk),
    .rst   (rst),
    .update(b_move),
    .item  (b_item),
    .cfg   (cfg),
    .res   (alarm_res)
  );

  // Result register.
  scaled_t out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= b_move || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_res  <= alarm_res;
      out_item <= b_item;
    end
  end

  assign led_on        = out_res.led_on;
  assign beep_phase    = out_res.beep_phase;
  assign tone_hz       = out_res.tone_hz;
  assign alarm_state   = out_res.alarm_state;
  assign state_changed = out_res.state_changed;
  assign mute_started  = out_res.mute_started;
  assign temp_status   = out_item.temp_status;
  assign pulse_status  = out_item.pulse_status;
  assign temp_tenths   = out_item.temp_tenths;
  assign pulse_bpm     = out_item.pulse_bpm;

  // A critical state always drives the LED on, a normal state always off.
  a_led_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_res.alarm_state != ALARM_CRITICAL || out_res.led_on) &&
                   (out_res.alarm_state != ALARM_NORMAL || !out_res.led_on)))
    else $error("LED level does not match alarm state");

  // A button pass keeps the alarm state.
  a_press_keeps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.mute_started |-> !out_res.state_changed)
    else $error("state changed on a button pass");

  // A sounding tone only happens in the on phase of the beep.
  a_tone_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.tone_hz != '0) |-> out_res.beep_phase)
    else $error("tone sounding while beep phase is off");

  // Without a button press the alarm state is critical exactly when both readings are out of range.
  a_state_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.mute_started |->
      ((out_res.alarm_state == ALARM_CRITICAL) ==
       (out_item.temp_status != LEVEL_NORMAL && out_item.pulse_status != LEVEL_NORMAL)))
    else $error("alarm state does not follow the readings");

  // The result register holds its item while the output is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res) && $stable(out_item))
    else $error("result lost or changed while stalled");

endmodule

### src/vsac_scale.sv
// ----------------------------------------------------------------------------
// vsac_scale: reading scaler and classifier
// Scales the raw readings by a fixed-point reciprocal of the ADC full scale,
// saturates them and classifies each one against the configured limits.
// ----------------------------------------------------------------------------
module vsac_scale #(
  parameter int ADC_FULL_SCALE = 1023
) (
  input  logic [vsac_pkg::RAW_W-1:0] temp_raw,
  input  logic [vsac_pkg::RAW_W-1:0] pulse_raw,
  input  logic                       tick_advance,
  input  logic                       button_press,
  input  vsac_pkg::cfg_t             cfg,
  output vsac_pkg::scaled_t          item
);
  import vsac_pkg::*;

  // Rounded-up reciprocals; the shift is wide enough that the truncated
  // product equals the floor quotient for every raw value at the default full scale.
  localparam logic [63:0] DIV      = 64'(ADC_FULL_SCALE);
  localparam logic [63:0] T_MULT   = ((64'(TEMP_SAT) << SCALE_SHIFT) + DIV - 64'd1) / DIV;
  localparam logic [63:0] P_MULT   = ((64'(PULSE_SPAN) << SCALE_SHIFT) + DIV - 64'd1) / DIV;
  localparam int          T_MULT_W = $clog2(T_MULT + 64'd1);
  localparam int          P_MULT_W = $clog2(P_MULT + 64'd1);
  localparam int          T_PROD_W = RAW_W + T_MULT_W;
  localparam int          P_PROD_W = RAW_W + P_MULT_W;

  logic [T_PROD_W-1:0] temp_prod, temp_quo;
  logic [P_PROD_W-1:0] pulse_prod, pulse_quo;
  logic [TEMP_W-1:0]   temp_val;
  logic [PULSE_W-1:0]  pulse_val;

  always_comb begin
    temp_prod  = T_PROD_W'(temp_raw) * T_PROD_W'(T_MULT[T_MULT_W-1:0]);
    pulse_prod = P_PROD_W'(pulse_raw) * P_PROD_W'(P_MULT[P_MULT_W-1:0]);
    temp_quo   = temp_prod >> SCALE_SHIFT;
    pulse_quo  = pulse_prod >> SCALE_SHIFT;

    if (temp_quo > T_PROD_W'(TEMP_SAT)) begin
      temp_val = TEMP_W'(TEMP_SAT);
    end else begin
      temp_val = temp_quo[TEMP_W-1:0];
    end

    if (pulse_quo > P_PROD_W'(PULSE_MAX - PULSE_MIN)) begin
      pulse_val = PULSE_W'(PULSE_MAX);
    end else begin
      pulse_val = pulse_quo[PULSE_W-1:0] + PULSE_W'(PULSE_MIN);
    end

    item.tick_advance = tick_advance;
    item.button_press = button_press;
    item.temp_tenths  = temp_val;
    item.pulse_bpm    = pulse_val;
    item.temp_status  = classify(temp_val, cfg.temp_low, cfg.temp_high);
    item.pulse_status = classify({1'b0, pulse_val}, {1'b0, cfg.pulse_low},
                                 {1'b0, cfg.pulse_high});
  end

endmodule

### src/vsac_alarm.sv
// ----------------------------------------------------------------------------
// vsac_alarm: alarm state, LED and buzzer timing
// Holds the tick counter, the alarm state and the timer marks, and computes
// the result of one pass. The state is committed when update is high.
// ----------------------------------------------------------------------------
module vsac_alarm #(
  parameter int TICK_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  vsac_pkg::scaled_t    item,
  input  vsac_pkg::cfg_t       cfg,
  output vsac_pkg::alarm_res_t res
);
  import vsac_pkg::*;

  logic [TICK_BITS-1:0] tick_count, led_mark, beep_mark, mute_mark;
  logic [TICK_BITS-1:0] tick_count_next, led_mark_next, beep_mark_next, mute_mark_next;
  alarm_t               current_alarm, current_alarm_next;
  logic                 mute_active, mute_active_next;
  logic                 beep_on, beep_on_next;
  logic                 led_level, led_level_next;
  logic [TONE_W-1:0]    tone_level, tone_level_next;

  logic [TICK_BITS-1:0] led_elapsed, beep_elapsed, mute_elapsed;
  logic [6:0]           interval;
  logic [TONE_W-1:0]    tone_sel;
  logic                 any_out, both_out;
  alarm_t               class_alarm;

  always_comb begin
    tick_count_next    = tick_count + TICK_BITS'(item.tick_advance);
    current_alarm_next = current_alarm;
    mute_mark_next     = mute_mark;
    mute_active_next   = mute_active;
    led_mark_next      = led_mark;
    led_level_next     = led_level;
    beep_mark_next     = beep_mark;
    beep_on_next       = beep_on;
    tone_level_next    = tone_level;
    res.state_changed  = 1'b0;
    res.mute_started   = 1'b0;

    any_out  = (item.temp_status != LEVEL_NORMAL) || (item.pulse_status != LEVEL_NORMAL);
    both_out = (item.temp_status != LEVEL_NORMAL) && (item.pulse_status != LEVEL_NORMAL);
    class_alarm = both_out ? ALARM_CRITICAL : (any_out ? ALARM_ALERT : ALARM_NORMAL);

    if (item.button_press) begin
      mute_active_next = 1'b1;
      mute_mark_next   = tick_count_next;
      res.mute_started = 1'b1;
    end else if (class_alarm != current_alarm) begin
      current_alarm_next = class_alarm;
      res.state_changed  = 1'b1;
    end

    led_elapsed  = tick_count_next - led_mark;
    beep_elapsed = tick_count_next - beep_mark;
    mute_elapsed = tick_count_next - mute_mark_next;

    case (current_alarm_next)
      ALARM_NORMAL: begin
        led_level_next = 1'b0;
        interval       = BEEP_IVL_NORMAL;
        tone_sel       = TONE_NORMAL;
      end
      ALARM_ALERT: begin
        if (led_elapsed > TICK_BITS'(cfg.blink_ticks)) begin
          led_level_next = ~led_level;
          led_mark_next  = tick_count_next;
        end
        interval = BEEP_IVL_ALERT;
        tone_sel = TONE_ALERT;
      end
      default: begin
        led_level_next = 1'b1;
        interval       = BEEP_IVL_CRIT;
        tone_sel       = TONE_CRIT;
      end
    endcase

    if (mute_active_next && (mute_elapsed < TICK_BITS'(cfg.mute_ticks))) begin
      tone_level_next = '0;
    end else begin
      mute_active_next = 1'b0;
      if (beep_elapsed >= TICK_BITS'(interval)) begin
        beep_on_next    = ~beep_on;
        tone_level_next = beep_on ? '0 : tone_sel;
        beep_mark_next  = tick_count_next;
      end
    end

    res.led_on      = led_level_next;
    res.beep_phase  = beep_on_next;
    res.tone_hz     = tone_level_next;
    res.alarm_state = current_alarm_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      current_alarm <= ALARM_NORMAL;
      led_mark      <= '0;
      beep_mark     <= '0;
      mute_mark     <= '0;
      mute_active   <= 1'b0;
      beep_on       <= 1'b0;
      led_level     <= 1'b0;
      tone_level    <= '0;
    end else if (update) begin
      tick_count    <= tick_count_next;
      current_alarm <= current_alarm_next;
      led_mark      <= led_mark_next;
      beep_mark     <= beep_mark_next;
      mute_mark     <= mute_mark_next;
      mute_active   <= mute_active_next;
      beep_on       <= beep_on_next;
      led_level     <= led_level_next;
      tone_level    <= tone_level_next;
    end
  end

endmodule
